@@ hdl/mrfd_pkg.sv @@
package mrfd_pkg;

    localparam int FRAME_BYTES = 25;
    localparam int DATA_BYTES  = FRAME_BYTES - 2;
    localparam int FIELD_BYTES = 23;
    localparam int STORE_DEPTH = 32;
    localparam int POS_W       = $clog2(STORE_DEPTH);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_CRC   = 2'd1;
    localparam logic [1:0] STATUS_SHORT = 2'd2;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_LAST,
        KIND_ABORT
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } item_t;

    function automatic logic [15:0] crc_step(input logic [15:0] c);
        logic [15:0] shifted;
        shifted = c >> 1;
        return c[0] ? (shifted ^ CRC_POLY) : shifted;
    endfunction

endpackage

@@ hdl/mrfd_front.sv @@
module mrfd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              action,
    input  logic [7:0]        rx_byte,
    input  logic              q_full,
    output logic              q_push,
    output mrfd_pkg::item_t   q_item
);

    logic [mrfd_pkg::POS_W-1:0] count_reg;
    logic [mrfd_pkg::POS_W-1:0] count_next;
    logic                       accept;
    logic                       keep;

    assign accept = push && !q_full;

    always_comb
    begin
        count_next  = count_reg;
        keep        = 1'b1;
        q_item.data = rx_byte;
        q_item.kind = mrfd_pkg::KIND_BYTE;
        if (action)
        begin
            // timeout with nothing received is dropped here
            if (count_reg == '0)
            begin
                keep = 1'b0;
            end
            else
            begin
                q_item.kind = mrfd_pkg::KIND_ABORT;
                count_next  = '0;
            end
        end
        else if (count_reg == mrfd_pkg::POS_W'(mrfd_pkg::FRAME_BYTES - 1))
        begin
            q_item.kind = mrfd_pkg::KIND_LAST;
            count_next  = '0;
        end
        else
        begin
            count_next = count_reg + 1'b1;
        end
    end

    assign q_push = accept && keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ hdl/mrfd_queue.sv @@
module mrfd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  mrfd_pkg::item_t wr_item,
    input  logic            rd_en,
    output mrfd_pkg::item_t rd_item,
    output logic            q_empty,
    output logic            q_full
);

    mrfd_pkg::item_t             entry_reg [mrfd_pkg::QUEUE_DEPTH];
    logic [mrfd_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [mrfd_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [mrfd_pkg::QCNT_W-1:0] count_reg;
    logic                        do_wr;
    logic                        do_rd;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == mrfd_pkg::QCNT_W'(mrfd_pkg::QUEUE_DEPTH));
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ hdl/mrfd_back.sv @@
module mrfd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  mrfd_pkg::item_t q_item,
    input  logic            q_empty,
    output logic            q_pop,
    input  logic            pop,
    output logic            empty,
    output logic [1:0]      status,
    output logic [15:0]     voltage_raw,
    output logic [31:0]     current_raw,
    output logic [31:0]     power_raw,
    output logic [31:0]     energy_raw,
    output logic [15:0]     frequency_raw,
    output logic [15:0]     factor_raw,
    output logic [15:0]     alarm_word
);

    typedef enum logic {
        ST_IDLE,
        ST_SHIFT
    } state_t;

    localparam logic [2:0] SHIFT_LAST = 3'd6;

    state_t                     state_reg, state_next;
    logic [2:0]                 bit_reg, bit_next;
    logic [15:0]                crc_reg, crc_next;
    logic [mrfd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       valid_reg, valid_next;
    logic [1:0]                 status_reg, status_next;
    logic [15:0]                voltage_reg, voltage_next;
    logic [31:0]                current_reg, current_next;
    logic [31:0]                power_reg, power_next;
    logic [31:0]                energy_reg, energy_next;
    logic [15:0]                frequency_reg, frequency_next;
    logic [15:0]                factor_reg, factor_next;
    logic [15:0]                alarm_reg, alarm_next;

    logic [7:0]  store_reg [mrfd_pkg::STORE_DEPTH];
    logic [7:0]  dbyte [mrfd_pkg::FIELD_BYTES];
    logic        store_wr;
    logic        slot_free;
    logic        load;
    logic [15:0] got_crc;

    assign slot_free = !valid_reg || pop;
    assign got_crc   = {q_item.data, store_reg[mrfd_pkg::POS_W'(mrfd_pkg::FRAME_BYTES - 2)]};

    always_comb
    begin
        for (int i = 0; i < mrfd_pkg::FIELD_BYTES; i++)
        begin
            dbyte[i] = (i < mrfd_pkg::DATA_BYTES) ? store_reg[mrfd_pkg::POS_W'(i)] : 8'd0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        bit_next       = bit_reg;
        crc_next       = crc_reg;
        pos_next       = pos_reg;
        valid_next     = valid_reg && !pop;
        status_next    = status_reg;
        voltage_next   = voltage_reg;
        current_next   = current_reg;
        power_next     = power_reg;
        energy_next    = energy_reg;
        frequency_next = frequency_reg;
        factor_next    = factor_reg;
        alarm_next     = alarm_reg;
        q_pop          = 1'b0;
        store_wr       = 1'b0;
        load           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_item.kind)
                        mrfd_pkg::KIND_BYTE:
                        begin
                            q_pop    = 1'b1;
                            store_wr = 1'b1;
                            pos_next = pos_reg + 1'b1;
                            if (pos_reg < mrfd_pkg::POS_W'(mrfd_pkg::DATA_BYTES))
                            begin
                                crc_next   = mrfd_pkg::crc_step(crc_reg ^ {8'd0, q_item.data});
                                bit_next   = '0;
                                state_next = ST_SHIFT;
                            end
                        end
                        mrfd_pkg::KIND_LAST,
                        mrfd_pkg::KIND_ABORT:
                        begin
                            if (slot_free)
                            begin
                                q_pop          = 1'b1;
                                load           = 1'b1;
                                valid_next     = 1'b1;
                                crc_next       = mrfd_pkg::CRC_INIT;
                                pos_next       = '0;
                                status_next    = mrfd_pkg::STATUS_SHORT;
                                voltage_next   = '0;
                                current_next   = '0;
                                power_next     = '0;
                                energy_next    = '0;
                                frequency_next = '0;
                                factor_next    = '0;
                                alarm_next     = '0;
                                if (q_item.kind == mrfd_pkg::KIND_LAST)
                                begin
                                    if (got_crc != crc_reg)
                                    begin
                                        status_next = mrfd_pkg::STATUS_CRC;
                                    end
                                    else
                                    begin
                                        status_next    = mrfd_pkg::STATUS_OK;
                                        voltage_next   = {dbyte[3], dbyte[4]};
                                        current_next   = {dbyte[7], dbyte[8], dbyte[5], dbyte[6]};
                                        power_next     = {dbyte[11], dbyte[12], dbyte[9], dbyte[10]};
                                        energy_next    = {dbyte[15], dbyte[16], dbyte[13], dbyte[14]};
                                        frequency_next = {dbyte[17], dbyte[18]};
                                        factor_next    = {dbyte[19], dbyte[20]};
                                        alarm_next     = {dbyte[21], dbyte[22]};
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SHIFT:
            begin
                crc_next = mrfd_pkg::crc_step(crc_reg);
                bit_next = bit_reg + 1'b1;
                if (bit_reg == SHIFT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            store_reg[pos_reg] <= q_item.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_reg       <= '0;
            crc_reg       <= mrfd_pkg::CRC_INIT;
            pos_reg       <= '0;
            valid_reg     <= 1'b0;
            status_reg    <= mrfd_pkg::STATUS_OK;
            voltage_reg   <= '0;
            current_reg   <= '0;
            power_reg     <= '0;
            energy_reg    <= '0;
            frequency_reg <= '0;
            factor_reg    <= '0;
            alarm_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_reg       <= bit_next;
            crc_reg       <= crc_next;
            pos_reg       <= pos_next;
            valid_reg     <= valid_next;
            status_reg    <= status_next;
            voltage_reg   <= voltage_next;
            current_reg   <= current_next;
            power_reg     <= power_next;
            energy_reg    <= energy_next;
            frequency_reg <= frequency_next;
            factor_reg    <= factor_next;
            alarm_reg     <= alarm_next;
        end
    end

    assign empty         = !valid_reg;
    assign status        = status_reg;
    assign voltage_raw   = voltage_reg;
    assign current_raw   = current_reg;
    assign power_raw     = power_reg;
    assign energy_raw    = energy_reg;
    assign frequency_raw = frequency_reg;
    assign factor_raw    = factor_reg;
    assign alarm_word    = alarm_reg;

    a_no_pop_while_shifting: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> !q_pop)
        else $error("request taken during crc shift");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || pop))
        else $error("result overwrote a waiting result");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (crc_reg == mrfd_pkg::CRC_INIT) && (pos_reg == '0) && !empty)
        else $error("frame state not restarted after result");

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < mrfd_pkg::POS_W'(mrfd_pkg::FRAME_BYTES))
        else $error("byte position past frame end");

endmodule

@@ hdl/meter_response_frame_decoder.sv @@
// energy meter reply decoder, read-input-registers response with crc-16 check
// input channel: push/full with action and rx_byte; a request is taken when
//   push is high and full is low; action 1 is a receive timeout
// result channel: empty/pop; while empty is low the oldest result is on
//   status and the raw value ports; pop with empty low takes it
// front stage counts bytes of the frame, drops a timeout with no frame in
//   progress and tags the last byte; a 4-entry queue feeds the back stage
// back stage stores bytes and runs the crc one bit per cycle: each data byte
//   is folded in bit by bit, while the two crc bytes and a timeout run no
//   crc shift, so the bit-serial crc sets how fast a full frame is taken
// a last byte or timeout is written to a queue entry; its result is then
//   registered in the result slot once the requests ahead of it are taken,
//   the back stage is idle and the slot is free; the queue absorbs up to 4 requests
// reset clears the frame position, the crc to all ones and the result slot
// a stalled receiver holds the result; the back stage then waits on the next
//   frame end, the queue fills and full rises until pop is given
module meter_response_frame_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        action,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [15:0] voltage_raw,
    output logic [31:0] current_raw,
    output logic [31:0] power_raw,
    output logic [31:0] energy_raw,
    output logic [15:0] frequency_raw,
    output logic [15:0] factor_raw,
    output logic [15:0] alarm_word
);

    mrfd_pkg::item_t wr_item;
    mrfd_pkg::item_t rd_item;
    logic            q_push;
    logic            q_pop;
    logic            q_empty;
    logic            q_full;

    assign full = q_full;

    mrfd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .action  (action),
        .rx_byte (rx_byte),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (wr_item)
    );

    mrfd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (wr_item),
        .rd_en   (q_pop),
        .rd_item (rd_item),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    mrfd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_item        (rd_item),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .status        (status),
        .voltage_raw   (voltage_raw),
        .current_raw   (current_raw),
        .power_raw     (power_raw),
        .energy_raw    (energy_raw),
        .frequency_raw (frequency_raw),
        .factor_raw    (factor_raw),
        .alarm_word    (alarm_word)
    );

endmodule
